/* rtl/core/sfr_pkg.sv */
// sfr_pkg: shared types and constants for the stream find/replace block.
// No dependencies.
package sfr_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_FIND_TEXT = 2'd0;
    localparam logic [1:0] REG_FIND_LEN  = 2'd1;
    localparam logic [1:0] REG_REPL_TEXT = 2'd2;
    localparam logic [1:0] REG_REPL_LEN  = 2'd3;

    typedef enum logic [1:0] {
        ENC_ASCII = 2'd0,
        ENC_LE    = 2'd1,
        ENC_BE    = 2'd2
    } t_enc;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    // One item handed from the front to the back.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_item;

    // One result byte with its flags.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
    } t_res;

endpackage

/* rtl/core/sfr_fifo.sv */
// sfr_fifo: small synchronous queue with registered slots.
// Depends on nothing; used for the item queue and the result queue.
module sfr_fifo #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= (AW+1)'(DEPTH);
    endproperty
    assert property (p_no_overflow) else $error("fifo count beyond depth");

    property p_pop_nonempty;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_cnt == '0) |=> (r_cnt <= (AW+1)'(1));
    endproperty
    assert property (p_pop_nonempty) else $error("fifo count jumped");

    property p_empty_matches;
        @(posedge i_clk) disable iff (!i_rst_n) o_empty == (r_cnt == '0);
    endproperty
    assert property (p_empty_matches) else $error("fifo empty flag wrong");
endmodule

/* rtl/core/sfr_engine.sv */
// sfr_engine: back part; holds the window, decides matches one at a time and
// emits one result byte per cycle while the result side is not full. Depends on sfr_pkg.
module sfr_engine #(
    parameter int unsigned MAX_FIND_CHARS    = 4,
    parameter int unsigned MAX_REPLACE_CHARS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  sfr_pkg::t_item      i_item,
    output logic                o_item_take,
    input  logic [31:0]         i_find_text,
    input  logic [2:0]          i_find_length,
    input  logic [31:0]         i_replace_text,
    input  logic [2:0]          i_replace_length,
    output logic                o_res_valid,
    output sfr_pkg::t_res       o_res,
    output logic                o_step_end,
    output logic                o_eos,
    input  logic                i_res_full
);
    localparam int unsigned WB  = 2 * MAX_FIND_CHARS;
    localparam int unsigned CW  = $clog2(WB + 1);
    localparam int unsigned IW  = (WB > 1) ? $clog2(WB) : 1;
    localparam int unsigned RB  = (2 * MAX_REPLACE_CHARS > 1) ? 2 * MAX_REPLACE_CHARS : 1;
    localparam int unsigned RW  = $clog2(RB + 1);
    localparam int unsigned RIW = (RB > 1) ? $clog2(RB) : 1;

    sfr_pkg::t_state r_state, n_state;
    logic [7:0]      r_win [WB];
    logic [CW-1:0]   r_cnt;
    logic            r_eos;
    logic [7:0]      r_rbuf [RB];
    logic [RW-1:0]   r_rlen, r_ridx;
    logic [CW-1:0]   r_drop;

    // effective lengths
    logic [3:0] w_flen, w_rlen;
    always_comb begin
        w_flen = (i_find_length == 3'd0) ? 4'd1 : {1'b0, i_find_length};
        if (w_flen > 4'(MAX_FIND_CHARS)) w_flen = 4'(MAX_FIND_CHARS);
        w_rlen = {1'b0, i_replace_length};
        if (w_rlen > 4'(MAX_REPLACE_CHARS)) w_rlen = 4'(MAX_REPLACE_CHARS);
    end

    function automatic logic [7:0] f_enc_byte(input logic [31:0] text,
                                              input sfr_pkg::t_enc enc,
                                              input int unsigned k);
        logic [7:0] c;
        int unsigned ci;
        ci = (enc == sfr_pkg::ENC_ASCII) ? k : (k >> 1);
        c  = (ci < 4) ? text[8*(ci%4) +: 8] : 8'd0;
        unique case (enc)
            sfr_pkg::ENC_ASCII: f_enc_byte = c;
            sfr_pkg::ENC_LE:    f_enc_byte = k[0] ? 8'd0 : c;
            sfr_pkg::ENC_BE:    f_enc_byte = k[0] ? c : 8'd0;
            default:            f_enc_byte = c;
        endcase
    endfunction

    // per-encoding match status over the held bytes
    logic [2:0] w_yes, w_wait;
    logic [CW-1:0] w_need [3];
    always_comb begin
        for (int e = 0; e < 3; e++) begin
            logic ok;
            ok = 1'b1;
            w_need[e] = (e == 0) ? CW'(w_flen) : CW'({w_flen, 1'b0});
            for (int k = 0; k < WB; k++) begin
                if (CW'(k) < w_need[e] && CW'(k) < r_cnt &&
                    r_win[k] != f_enc_byte(i_find_text, sfr_pkg::t_enc'(e), k))
                    ok = 1'b0;
            end
            w_yes[e]  = ok && (w_need[e] <= r_cnt);
            w_wait[e] = ok && (w_need[e] > r_cnt) && !r_eos;
        end
    end

    // decision in priority LE, BE, ASCII
    logic          w_stop, w_hit;
    sfr_pkg::t_enc w_enc;
    always_comb begin
        w_stop = 1'b0; w_hit = 1'b0; w_enc = sfr_pkg::ENC_ASCII;
        priority if (w_wait[sfr_pkg::ENC_LE] ) w_stop = 1'b1;
        else if (w_yes[sfr_pkg::ENC_LE]) begin w_hit = 1'b1; w_enc = sfr_pkg::ENC_LE; end
        else if (w_wait[sfr_pkg::ENC_BE]) w_stop = 1'b1;
        else if (w_yes[sfr_pkg::ENC_BE]) begin w_hit = 1'b1; w_enc = sfr_pkg::ENC_BE; end
        else if (w_wait[sfr_pkg::ENC_ASCII]) w_stop = 1'b1;
        else if (w_yes[sfr_pkg::ENC_ASCII]) w_hit = 1'b1;
        else w_stop = 1'b0;
    end

    logic w_done;       // nothing more to decide this step
    logic w_step_end;   // step closes; waits while the result side is full
    logic w_emit_done;  // last byte of the burst goes out (or burst is empty)
    assign w_done      = (r_cnt == '0) || w_stop;
    assign w_step_end  = (r_state == sfr_pkg::ST_SCAN) && w_done && !i_res_full;
    assign w_emit_done = (r_rlen == '0) || (!i_res_full && (r_ridx + RW'(1) >= r_rlen));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfr_pkg::ST_IDLE: begin
                if (i_item_valid) n_state = sfr_pkg::ST_SCAN;
            end
            sfr_pkg::ST_SCAN: begin
                if (!w_done) n_state = sfr_pkg::ST_EMIT;
                else if (!i_res_full) n_state = sfr_pkg::ST_IDLE;
            end
            sfr_pkg::ST_EMIT: begin
                if (w_emit_done) n_state = sfr_pkg::ST_SCAN;
            end
            default: n_state = sfr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_item_take = (r_state == sfr_pkg::ST_IDLE) && i_item_valid;
        o_res_valid = (r_state == sfr_pkg::ST_EMIT) && (r_rlen != '0) && !i_res_full;
        o_res.out_byte    = r_rbuf[r_ridx[RIW-1:0]];
        o_res.run_last    = 1'b0;
        o_res.stream_done = 1'b0;
        o_step_end  = w_step_end;
        o_eos       = r_eos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_eos   <= 1'b0;
            r_ridx  <= '0;
            r_rlen  <= '0;
            r_drop  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                sfr_pkg::ST_IDLE: begin
                    if (i_item_valid) begin
                        if (r_cnt < CW'(WB)) begin
                            r_win[r_cnt[IW-1:0]] <= i_item.in_byte;
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_eos <= i_item.end_of_stream;
                    end
                end
                sfr_pkg::ST_SCAN: begin
                    r_ridx <= '0;
                    if (w_done) begin
                        if (w_step_end && r_eos) r_cnt <= '0;
                    end else if (w_hit) begin
                        for (int k = 0; k < RB; k++)
                            r_rbuf[k] <= f_enc_byte(i_replace_text, w_enc, k);
                        r_rlen <= (w_enc == sfr_pkg::ENC_ASCII) ? RW'(w_rlen) : RW'({w_rlen, 1'b0});
                        r_drop <= w_need[w_enc];
                    end else begin
                        r_rbuf[0] <= r_win[0];
                        r_rlen    <= RW'(1);
                        r_drop    <= CW'(1);
                    end
                end
                sfr_pkg::ST_EMIT: begin
                    if (w_emit_done) begin
                        for (int k = 0; k < WB; k++)
                            if ((CW+1)'(k) + (CW+1)'(r_drop) < (CW+1)'(WB))
                                r_win[k] <= r_win[IW'(CW'(k) + r_drop)];
                        r_cnt <= r_cnt - r_drop;
                    end else if (!i_res_full) begin
                        r_ridx <= r_ridx + RW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    property p_take_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_item_take |-> r_state == sfr_pkg::ST_IDLE;
    endproperty
    assert property (p_take_idle) else $error("item taken while busy");

    property p_cnt_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CW'(WB);
    endproperty
    assert property (p_cnt_bound) else $error("window overfilled");

    property p_res_emit;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_res_valid |-> r_state == sfr_pkg::ST_EMIT;
    endproperty
    assert property (p_res_emit) else $error("result outside emit");

    property p_end_not_full;
        @(posedge i_clk) disable iff (!i_rst_n) o_step_end |-> !i_res_full;
    endproperty
    assert property (p_end_not_full) else $error("step closed into full queue");
endmodule

/* rtl/core/sfr_tagger.sv */
// sfr_tagger: holds one result back so the last byte of a step can be
// flagged run_last/stream_done. Depends on sfr_pkg.
module sfr_tagger (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sfr_pkg::t_res i_res,
    input  logic          i_step_end,
    input  logic          i_eos,
    input  logic          i_full,
    output logic          o_push,
    output sfr_pkg::t_res o_res
);
    logic          r_have;
    sfr_pkg::t_res r_res;

    always_comb begin
        o_res = r_res;
        o_res.run_last    = i_step_end;
        o_res.stream_done = i_step_end && i_eos;
        o_push = r_have && !i_full && (i_valid || i_step_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            if (i_valid) begin
                r_have <= 1'b1;
            end else if (o_push) begin
                r_have <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) r_res <= i_res;
    end

    property p_no_lost;
        @(posedge i_clk) disable iff (!i_rst_n) i_valid && r_have |-> !i_full;
    endproperty
    assert property (p_no_lost) else $error("held result overwritten");

    property p_push_has;
        @(posedge i_clk) disable iff (!i_rst_n) o_push |-> r_have;
    endproperty
    assert property (p_push_has) else $error("push without data");

    property p_end_clears;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_push && !i_valid) |=> !r_have;
    endproperty
    assert property (p_end_clears) else $error("tag slot not freed");
endmodule

/* rtl/core/stream_find_replace_three_encodings.sv */
// Top level of the stream find/replace block (ASCII, UTF-16LE, UTF-16BE).
// Depends on sfr_pkg, sfr_fifo, sfr_engine, sfr_tagger.
//
//  channel | direction | handshake        | payload
//  input   | in        | push / full      | i_in_byte, i_end_of_stream
//  result  | out       | empty / pop      | o_out_byte, o_run_last, o_stream_done
//  config  | in        | i_cfg_we         | i_cfg_index, i_cfg_data
//
// Flow: the engine takes an item in IDLE, then scans; each decision is made
// in a scan and followed by an emit of its output bytes (an empty replacement
// emits nothing), and a closing scan ends the step. Items pass through the
// input queue before the take, and results through the result queue.
// Reset: synchronous active low; clears queues, window count and registers.
// Stalls: a full result queue holds the emitter and the step close; the
// input queue keeps taking transfers until it fills.
module stream_find_replace_three_encodings #(
    parameter int unsigned MAX_FIND_CHARS    = 4,
    parameter int unsigned MAX_REPLACE_CHARS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_stream,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_stream_done,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_find_text, r_replace_text;
    logic [2:0]  r_find_length, r_replace_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_text      <= '0;
            r_find_length    <= 3'd1;
            r_replace_text   <= '0;
            r_replace_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfr_pkg::REG_FIND_TEXT: r_find_text      <= i_cfg_data;
                sfr_pkg::REG_FIND_LEN:  r_find_length    <= i_cfg_data[2:0];
                sfr_pkg::REG_REPL_TEXT: r_replace_text   <= i_cfg_data;
                sfr_pkg::REG_REPL_LEN:  r_replace_length <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // front: input queue
    sfr_pkg::t_item w_in_item, w_q_item;
    logic           w_q_empty, w_take;
    assign w_in_item = '{in_byte: i_in_byte, end_of_stream: i_end_of_stream};

    sfr_fifo #(.WIDTH($bits(sfr_pkg::t_item)), .DEPTH(4)) u_in_q (
        .i_clk, .i_rst_n,
        .i_push(push), .i_data(w_in_item), .o_full(full),
        .i_pop(w_take), .o_empty(w_q_empty), .o_data(w_q_item)
    );

    // back: engine
    logic          w_eng_valid, w_res_full, w_push;
    sfr_pkg::t_res w_eng_res, w_tag_res;
    logic          w_tag_full;
    logic          w_step_end, w_eng_eos;

    // the engine also holds its step close while the result queue is full,
    // so the tagger always has room for the byte it releases
    assign w_tag_full = w_res_full;

    sfr_engine #(.MAX_FIND_CHARS(MAX_FIND_CHARS),
                 .MAX_REPLACE_CHARS(MAX_REPLACE_CHARS)) u_eng (
        .i_clk, .i_rst_n,
        .i_item_valid(!w_q_empty), .i_item(w_q_item), .o_item_take(w_take),
        .i_find_text(r_find_text), .i_find_length(r_find_length),
        .i_replace_text(r_replace_text), .i_replace_length(r_replace_length),
        .o_res_valid(w_eng_valid), .o_res(w_eng_res),
        .o_step_end(w_step_end), .o_eos(w_eng_eos), .i_res_full(w_tag_full)
    );

    // tagger holds the newest byte until the next one arrives or the step closes, and flags it at the close
    sfr_tagger u_tag (
        .i_clk, .i_rst_n,
        .i_valid(w_eng_valid), .i_res(w_eng_res),
        .i_step_end(w_step_end), .i_eos(w_eng_eos),
        .i_full(w_res_full), .o_push(w_push), .o_res(w_tag_res)
    );

    sfr_pkg::t_res w_out;
    sfr_fifo #(.WIDTH($bits(sfr_pkg::t_res)), .DEPTH(4)) u_out_q (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_data(w_tag_res), .o_full(w_res_full),
        .i_pop(pop), .o_empty(empty), .o_data(w_out)
    );

    assign o_out_byte    = w_out.out_byte;
    assign o_run_last    = w_out.run_last;
    assign o_stream_done = w_out.stream_done;

    property p_full_no_take;
        @(posedge i_clk) disable iff (!i_rst_n) w_res_full |-> !w_push;
    endproperty
    assert property (p_full_no_take) else $error("push into full result queue");

    property p_take_has_item;
        @(posedge i_clk) disable iff (!i_rst_n) w_take |-> !w_q_empty;
    endproperty
    assert property (p_take_has_item) else $error("take from empty input queue");

    property p_done_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            (!empty && o_stream_done) |-> o_run_last;
    endproperty
    assert property (p_done_last) else $error("stream_done without run_last");
endmodule

/* verif/stream_find_replace_three_encodings_tb.sv */
// Testbench for stream_find_replace_three_encodings: directed table, then random streams
// checked against a behavioral predictor of the find/replace rewrite.
// Depends on sfr_pkg and the RTL top level.
module stream_find_replace_three_encodings_tb;

    localparam int WIN = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        i_end_of_stream;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_run_last;
    logic        o_stream_done;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    stream_find_replace_three_encodings uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_byte(i_in_byte), .i_end_of_stream(i_end_of_stream),
        .empty(empty), .pop(pop), .o_out_byte(o_out_byte),
        .o_run_last(o_run_last), .o_stream_done(o_stream_done),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // predictor copy of the registers and the undecided window
    logic [31:0] pat_text, rep_text;
    logic [2:0]  pat_len, rep_len;
    logic [7:0]  win_q [WIN];
    int          win_cnt;

    sfr_pkg::t_res rewrite_q [$];   // expected output bytes, oldest first
    bit   failed;
    int   send_idle_pct, recv_stall_pct;

    function automatic logic [7:0] char_at(logic [31:0] text, int i);
        return (i >= 4) ? 8'h00 : text[8*i +: 8];
    endfunction

    function automatic logic [7:0] coded_byte(logic [31:0] text, sfr_pkg::t_enc enc, int k);
        case (enc)
            sfr_pkg::ENC_ASCII: return char_at(text, k);
            sfr_pkg::ENC_LE:    return (k % 2) ? 8'h00 : char_at(text, k / 2);
            default:            return (k % 2) ? char_at(text, k / 2) : 8'h00;
        endcase
    endfunction

    function automatic int coded_len(sfr_pkg::t_enc enc, int chars);
        return (enc == sfr_pkg::ENC_ASCII) ? chars : 2 * chars;
    endfunction

    function automatic int find_chars();
        if (pat_len == 0) return 1;
        return (pat_len > 4) ? 4 : int'(pat_len);
    endfunction

    function automatic int repl_chars();
        return (rep_len > 4) ? 4 : int'(rep_len);
    endfunction

    // 0 no match, 1 match, 2 undecided
    function automatic int match_state(sfr_pkg::t_enc enc, bit eos);
        int need;
        need = coded_len(enc, find_chars());
        for (int k = 0; k < need && k < win_cnt; k++)
            if (win_q[k] != coded_byte(pat_text, enc, k)) return 0;
        if (need > win_cnt) return eos ? 0 : 2;
        return 1;
    endfunction

    function automatic void shift_out(int n);
        if (n > win_cnt) n = win_cnt;
        for (int k = 0; k < WIN; k++)
            win_q[k] = (k + n < WIN) ? win_q[k + n] : 8'h00;
        win_cnt -= n;
    endfunction

    // Predict all output bytes caused by one accepted input byte.
    function automatic void predict_rewrite(logic [7:0] b, bit eos);
        sfr_pkg::t_enc order [3];
        sfr_pkg::t_res step_q [$];
        sfr_pkg::t_res r;
        bit   waiting, matched;
        int   st;
        order = '{sfr_pkg::ENC_LE, sfr_pkg::ENC_BE, sfr_pkg::ENC_ASCII};
        if (win_cnt < WIN) begin
            win_q[win_cnt] = b;
            win_cnt++;
        end
        while (win_cnt > 0) begin
            waiting = 0;
            matched = 0;
            for (int i = 0; i < 3; i++) begin
                st = match_state(order[i], eos);
                if (st == 2) begin
                    waiting = 1;
                    break;
                end
                if (st == 1) begin
                    for (int k = 0; k < coded_len(order[i], repl_chars()); k++) begin
                        r = '{coded_byte(rep_text, order[i], k), 1'b0, 1'b0};
                        step_q = {step_q, r};
                    end
                    shift_out(coded_len(order[i], find_chars()));
                    matched = 1;
                    break;
                end
            end
            if (waiting) break;
            if (!matched) begin
                r = '{win_q[0], 1'b0, 1'b0};
                step_q = {step_q, r};
                shift_out(1);
            end
        end
        if (eos) win_cnt = 0;
        if (step_q.size() > 0) begin
            step_q[$].run_last = 1'b1;
            step_q[$].stream_done = eos;
        end
        rewrite_q = {rewrite_q, step_q};
    endfunction

    // Write enable stays high until the caller drops it after its last write.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            sfr_pkg::REG_FIND_TEXT: pat_text = val;
            sfr_pkg::REG_FIND_LEN:  pat_len  = val[2:0];
            sfr_pkg::REG_REPL_TEXT: rep_text = val;
            sfr_pkg::REG_REPL_LEN:  rep_len  = val[2:0];
            default: ;
        endcase
    endtask

    // Wait until every expected byte is out, then let the engine settle.
    task automatic drain_idle();
        push <= 1'b0;
        while (rewrite_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] ft, logic [2:0] fl, logic [31:0] rt, logic [2:0] rl);
        drain_idle();
        write_reg(sfr_pkg::REG_FIND_TEXT, ft);
        write_reg(sfr_pkg::REG_FIND_LEN, {29'd0, fl});
        write_reg(sfr_pkg::REG_REPL_TEXT, rt);
        write_reg(sfr_pkg::REG_REPL_LEN, {29'd0, rl});
        i_cfg_we <= 1'b0;
    endtask

    // One input transfer; the prediction is made when it is accepted.
    // push stays high after the transfer; idle cycles and pauses drop it.
    task automatic send_byte(logic [7:0] b, bit eos);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_in_byte       <= b;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_rewrite(b, eos);
    endtask

    // Result side: random stalls on pop, compare each accepted transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (rewrite_q.size() == 0) begin
                    $error("out_byte expected none actual %0h", o_out_byte);
                    failed = 1;
                end else begin
                    if (o_out_byte !== rewrite_q[0].out_byte) begin
                        $error("out_byte expected %0h actual %0h",
                               rewrite_q[0].out_byte, o_out_byte);
                        failed = 1;
                    end
                    if (o_run_last !== rewrite_q[0].run_last) begin
                        $error("run_last expected %0b actual %0b",
                               rewrite_q[0].run_last, o_run_last);
                        failed = 1;
                    end
                    if (o_stream_done !== rewrite_q[0].stream_done) begin
                        $error("stream_done expected %0b actual %0b",
                               rewrite_q[0].stream_done, o_stream_done);
                        failed = 1;
                    end
                    void'(rewrite_q.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Directed table: byte, eos flag.  First rows after reset (pattern 0x00,
    // length 1, empty replacement) have outputs readable at a glance.
    typedef struct {
        logic [7:0] b;
        bit         eos;
    } t_row;

    t_row dir_rows [22] = '{
        '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'h41, 1'b1},
        // pattern "AB", replacement "xyz" (set below)
        '{8'h41, 1'b0}, '{8'h42, 1'b0}, '{8'h41, 1'b0}, '{8'h00, 1'b0},
        '{8'h42, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h41, 1'b0},
        '{8'h00, 1'b0}, '{8'h42, 1'b0}, '{8'h41, 1'b1},
        '{8'h41, 1'b0}, '{8'h00, 1'b1}, '{8'h00, 1'b0}, '{8'h41, 1'b1},
        '{8'h80, 1'b0}, '{8'h7F, 1'b0}, '{8'h41, 1'b0}, '{8'h42, 1'b1}
    };

    logic [31:0] ft;
    logic [7:0]  rb;

    initial begin
        failed = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        push = 1'b0; i_in_byte = 8'h00; i_end_of_stream = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = sfr_pkg::REG_FIND_TEXT; i_cfg_data = '0;
        pat_text = 0; pat_len = 1; rep_text = 0; rep_len = 0;
        win_cnt = 0;
        for (int k = 0; k < WIN; k++) win_q[k] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: 0x00 is deleted, others pass straight through
        send_byte(dir_rows[0].b, dir_rows[0].eos);
        if (rewrite_q.size() != 0) begin
            $error("out_byte expected none actual %0d queued", rewrite_q.size());
            failed = 1;
        end
        for (int i = 1; i < 3; i++) send_byte(dir_rows[i].b, dir_rows[i].eos);
        configure(32'h0000_4241, 3'd2, 32'h007A_7978, 3'd3);
        for (int i = 3; i < 18; i++) send_byte(dir_rows[i].b, dir_rows[i].eos);
        // extremes: empty pattern code, oversized lengths, all-ones text
        configure(32'hFFFF_FFFF, 3'd0, 32'hFFFF_FFFF, 3'd7);
        for (int i = 18; i < 22; i++) send_byte(dir_rows[i].b, dir_rows[i].eos);
        send_byte(8'hFF, 1'b1);
        configure(32'h4443_4241, 3'd7, 32'h0, 3'd0);
        send_byte(8'h41, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h42, 1'b1);

        // random streams across idling phases and settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            // small alphabet keeps matches frequent
            ft = {4{8'h40}} | {6'd0, 2'($urandom), 6'd0, 2'($urandom),
                               6'd0, 2'($urandom), 6'd0, 2'($urandom)};
            if ($urandom_range(4) == 0) ft = $urandom;
            configure(ft, 3'($urandom_range(ph == 7 ? 7 : 4)), $urandom,
                      3'($urandom_range(ph == 6 ? 7 : 4)));
            for (int n = 0; n < 56; n++) begin
                case ($urandom_range(9))
                    0, 1, 2: rb = 8'h00;
                    3, 4, 5, 6: rb = 8'h40 | 8'($urandom_range(3));
                    default: rb = 8'($urandom);
                endcase
                send_byte(rb, $urandom_range(15) == 0);
                if (n == 30 && ph == 3) begin
                    // hold off until the result side is fully drained
                    push <= 1'b0;
                    while (rewrite_q.size() != 0) @(posedge i_clk);
                end
            end
            send_byte(8'($urandom), 1'b1);
        end

        push <= 1'b0;
        recv_stall_pct = 0;
        while (rewrite_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed && rewrite_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
